/* sv/hs_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, payload types and controller/datapath interface for the heap sorter.
// No dependencies; every other file of the block except hs_ram imports this package.
package hs_pkg;

	localparam int MAX_ITEMS = 64;
	localparam int KEY_BITS  = 32;
	localparam int TAG_BITS  = 16;
	localparam int IDX_BITS  = $clog2(MAX_ITEMS);
	localparam int CNT_BITS  = $clog2(MAX_ITEMS + 1);
	// child index 2k+2 needs two more bits than a node index
	localparam int LIDX_BITS = IDX_BITS + 2;

	typedef struct packed {
		logic [KEY_BITS-1:0] key;
		logic [TAG_BITS-1:0] tag;
		logic                last_item;
	} in_item_t;

	typedef struct packed {
		logic [KEY_BITS-1:0] key_out;
		logic [TAG_BITS-1:0] tag_out;
		logic                last_out;
	} out_item_t;

	typedef struct packed {
		logic [KEY_BITS-1:0] key;
		logic [TAG_BITS-1:0] tag;
	} rec_t;

	localparam int REC_BITS = $bits(rec_t);

	typedef struct packed {
		logic store;        // write incoming record at the fill position
		logic init_sort;    // set heap end, build node and output index
		logic bld_read;     // read build node, take it as sift node
		logic held_from_rd; // capture read record as the sifted record
		logic bld_dec;      // step build node down
		logic ex_read_hi;   // read record at heap end
		logic ex_read_root; // read root
		logic ex_write;     // move root to heap end, shrink heap, sift from root
		logic read_left;    // read left child
		logic child_left;   // capture left child
		logic read_right;   // read right child
		logic child_right;  // capture right child
		logic write_held;   // place sifted record at the sift node
		logic write_child;  // raise child into the sift node, descend
		logic out_read;     // read record at output index
		logic out_emit;     // present record as a result, advance output index
		logic clear_count;  // empty the store
	} cmd_t;

	typedef struct packed {
		logic count_zero;
		logic count_one;
		logic left_gt_hi;
		logic right_le_hi;
		logic right_better;
		logic held_moves;
		logic bld_zero;
		logic hi_zero;
		logic out_last;
	} status_t;

endpackage

/* sv/heap_sorter_unit.sv */
`timescale 1ns / 1ps
// Heap sorter top level: controller plus datapath with the record RAM.
// Depends on hs_pkg, hs_ctrl, hs_datapath (which holds hs_ram).
//
//   channel   handshake                    payload             transfer when
//   input     start / busy                 item   (in_item_t)  start && !busy
//   result    result_valid (strobe)        result (out_item_t) result_valid
//   config    cfg_valid / cfg_ready        cfg_data (1 bit)    cfg_valid && cfg_ready
//
// A record without last_item is stored and busy stays low.
// On last_item the set of n records is heapsorted in place in a simple dual-port
// record RAM (one read and one write per cycle); each result is then read and emitted.
// Reset empties the store and selects ascending order; the RAM is not cleared.
// The result receiver cannot stall; each result shows for one cycle only.
module heap_sorter_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  hs_pkg::in_item_t  item,
	output hs_pkg::out_item_t result,
	output logic              result_valid,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_data
);
	import hs_pkg::*;

	cmd_t    cmd;
	status_t status;

	// Take an order write only while idle so the order never changes under a sort.
	assign cfg_ready = !busy;

	// Sequence load, build, extract and output phases.
	hs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.last_item(item.last_item),
		.status   (status),
		.cmd      (cmd),
		.busy     (busy)
	);

	// Hold records, sift registers, compares and the result register.
	hs_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.item        (item),
		.cfg_valid   (cfg_valid && cfg_ready),
		.cfg_data    (cfg_data),
		.result      (result),
		.result_valid(result_valid)
	);

endmodule

/* sv/hs_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* sv/hs_datapath.sv */
`timescale 1ns / 1ps
// Heap sorter datapath: record RAM, sift registers, counters, key compares, result register.
// Depends on hs_pkg and hs_ram.
module hs_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  hs_pkg::cmd_t     cmd,
	output hs_pkg::status_t  status,
	input  hs_pkg::in_item_t item,
	input  logic             cfg_valid,
	input  logic             cfg_data,
	output hs_pkg::out_item_t result,
	output logic             result_valid
);
	import hs_pkg::*;

	logic [CNT_BITS-1:0]  count_q;
	logic                 desc_q;
	logic [IDX_BITS-1:0]  hi_q;
	logic [IDX_BITS-1:0]  bld_q;
	logic [IDX_BITS-1:0]  k_q;
	logic [IDX_BITS-1:0]  cidx_q;
	logic [IDX_BITS-1:0]  oidx_q;
	rec_t                 held_q;
	rec_t                 child_q;
	out_item_t            result_q;
	logic                 result_valid_q;

	logic                 full;
	logic [LIDX_BITS-1:0] left_w;
	logic [LIDX_BITS-1:0] right_w;
	logic [LIDX_BITS-1:0] hi_w;
	logic [IDX_BITS-1:0]  hi_init;
	rec_t                 rd;
	rec_t                 wrec;
	logic                 ram_we;
	logic [IDX_BITS-1:0]  ram_waddr;
	logic [IDX_BITS-1:0]  ram_raddr;
	logic [REC_BITS-1:0]  ram_rdata;

	hs_ram #(
		.WIDTH(REC_BITS),
		.DEPTH(MAX_ITEMS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(wrec),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rd      = rec_t'(ram_rdata);
	assign full    = (count_q == CNT_BITS'(MAX_ITEMS));
	assign left_w  = {1'b0, k_q, 1'b1};
	assign right_w = left_w + LIDX_BITS'(1);
	assign hi_w    = {2'b00, hi_q};
	assign hi_init = IDX_BITS'(count_q - CNT_BITS'(1));

	always_comb begin
		status.count_zero   = (count_q == '0);
		status.count_one    = (count_q == CNT_BITS'(1));
		status.left_gt_hi   = (left_w > hi_w);
		status.right_le_hi  = (right_w <= hi_w);
		// maxheap for ascending output, minheap for descending
		status.right_better = desc_q ? (rd.key < child_q.key) : (child_q.key < rd.key);
		status.held_moves   = desc_q ? (child_q.key < held_q.key) : (held_q.key < child_q.key);
		status.bld_zero     = (bld_q == '0);
		status.hi_zero      = (hi_q == '0);
		status.out_last     = ((CNT_BITS'(oidx_q) + CNT_BITS'(1)) == count_q);
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = k_q;
		wrec      = held_q;
		if (cmd.store) begin
			ram_we    = !full;
			ram_waddr = count_q[IDX_BITS-1:0];
			wrec      = '{key: item.key, tag: item.tag};
		end else if (cmd.write_held) begin
			ram_we = 1'b1;
		end else if (cmd.write_child) begin
			ram_we = 1'b1;
			wrec   = child_q;
		end else if (cmd.ex_write) begin
			ram_we    = 1'b1;
			ram_waddr = hi_q;
			wrec      = rd;
		end
	end

	always_comb begin
		ram_raddr = oidx_q;
		if (cmd.bld_read) begin
			ram_raddr = bld_q;
		end else if (cmd.ex_read_hi) begin
			ram_raddr = hi_q;
		end else if (cmd.ex_read_root) begin
			ram_raddr = '0;
		end else if (cmd.read_left) begin
			ram_raddr = left_w[IDX_BITS-1:0];
		end else if (cmd.read_right) begin
			ram_raddr = right_w[IDX_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q        <= '0;
			desc_q         <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				desc_q <= cfg_data;
			end
			if (cmd.clear_count) begin
				count_q <= '0;
			end else if (cmd.store && !full) begin
				count_q <= count_q + CNT_BITS'(1);
			end
			result_valid_q <= cmd.out_emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.init_sort) begin
			hi_q   <= hi_init;
			bld_q  <= hi_init >> 1;
			oidx_q <= '0;
		end
		if (cmd.bld_read) begin
			k_q <= bld_q;
		end
		if (cmd.bld_dec) begin
			bld_q <= bld_q - IDX_BITS'(1);
		end
		if (cmd.held_from_rd) begin
			held_q <= rd;
		end
		if (cmd.ex_write) begin
			hi_q <= hi_q - IDX_BITS'(1);
			k_q  <= '0;
		end
		if (cmd.child_left) begin
			child_q <= rd;
			cidx_q  <= left_w[IDX_BITS-1:0];
		end
		if (cmd.child_right) begin
			child_q <= rd;
			cidx_q  <= right_w[IDX_BITS-1:0];
		end
		if (cmd.write_child) begin
			k_q <= cidx_q;
		end
		if (cmd.out_emit) begin
			result_q <= '{key_out: rd.key, tag_out: rd.tag, last_out: status.out_last};
			oidx_q   <= oidx_q + IDX_BITS'(1);
		end
	end

	assign result       = result_q;
	assign result_valid = result_valid_q;

endmodule

/* sv/hs_ctrl.sv */
`timescale 1ns / 1ps
// Heap sorter controller: sequences load, heap build, extraction and output.
// Depends on hs_pkg.
module hs_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            last_item,
	input  hs_pkg::status_t status,
	output hs_pkg::cmd_t    cmd,
	output logic            busy
);
	import hs_pkg::*;

	typedef enum logic [13:0] {
		ST_IDLE     = 14'b00000000000001,
		ST_SETUP    = 14'b00000000000010,
		ST_BLD_RD   = 14'b00000000000100,
		ST_BLD_LD   = 14'b00000000001000,
		ST_SIFT_L   = 14'b00000000010000,
		ST_SIFT_CL  = 14'b00000000100000,
		ST_SIFT_CR  = 14'b00000001000000,
		ST_SIFT_DEC = 14'b00000010000000,
		ST_SIFT_END = 14'b00000100000000,
		ST_EX_RD0   = 14'b00001000000000,
		ST_EX_RD1   = 14'b00010000000000,
		ST_EX_WR    = 14'b00100000000000,
		ST_OUT_RD   = 14'b01000000000000,
		ST_OUT_EM   = 14'b10000000000000
	} state_t;

	state_t state_q, state_d;
	logic   build_q, build_d;

	always_comb begin
		state_d = state_q;
		build_d = build_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.store = 1'b1;
					if (last_item) begin
						state_d = ST_SETUP;
					end
				end
			end
			ST_SETUP: begin
				cmd.init_sort = 1'b1;
				if (status.count_zero) begin
					cmd.clear_count = 1'b1;
					state_d         = ST_IDLE;
				end else if (status.count_one) begin
					state_d = ST_OUT_RD;
				end else begin
					build_d = 1'b1;
					state_d = ST_BLD_RD;
				end
			end
			ST_BLD_RD: begin
				cmd.bld_read = 1'b1;
				state_d      = ST_BLD_LD;
			end
			ST_BLD_LD: begin
				cmd.held_from_rd = 1'b1;
				state_d          = ST_SIFT_L;
			end
			ST_SIFT_L: begin
				if (status.left_gt_hi) begin
					cmd.write_held = 1'b1;
					state_d        = ST_SIFT_END;
				end else begin
					cmd.read_left = 1'b1;
					state_d       = ST_SIFT_CL;
				end
			end
			ST_SIFT_CL: begin
				cmd.child_left = 1'b1;
				if (status.right_le_hi) begin
					cmd.read_right = 1'b1;
					state_d        = ST_SIFT_CR;
				end else begin
					state_d = ST_SIFT_DEC;
				end
			end
			ST_SIFT_CR: begin
				cmd.child_right = status.right_better;
				state_d         = ST_SIFT_DEC;
			end
			ST_SIFT_DEC: begin
				if (status.held_moves) begin
					cmd.write_child = 1'b1;
					state_d         = ST_SIFT_L;
				end else begin
					cmd.write_held = 1'b1;
					state_d        = ST_SIFT_END;
				end
			end
			ST_SIFT_END: begin
				if (build_q) begin
					if (status.bld_zero) begin
						build_d = 1'b0;
						state_d = ST_EX_RD0;
					end else begin
						cmd.bld_dec = 1'b1;
						state_d     = ST_BLD_RD;
					end
				end else if (status.hi_zero) begin
					state_d = ST_OUT_RD;
				end else begin
					state_d = ST_EX_RD0;
				end
			end
			ST_EX_RD0: begin
				cmd.ex_read_hi = 1'b1;
				state_d        = ST_EX_RD1;
			end
			ST_EX_RD1: begin
				cmd.held_from_rd = 1'b1;
				cmd.ex_read_root = 1'b1;
				state_d          = ST_EX_WR;
			end
			ST_EX_WR: begin
				cmd.ex_write = 1'b1;
				state_d      = ST_SIFT_L;
			end
			ST_OUT_RD: begin
				cmd.out_read = 1'b1;
				state_d      = ST_OUT_EM;
			end
			ST_OUT_EM: begin
				cmd.out_emit = 1'b1;
				if (status.out_last) begin
					cmd.clear_count = 1'b1;
					state_d         = ST_IDLE;
				end else begin
					state_d = ST_OUT_RD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			build_q <= 1'b0;
		end else begin
			state_q <= state_d;
			build_q <= build_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule
